// ===== rtl/icsb_pkg.sv =====
// Shared types and constants for the interpolating circular sample buffer.
package icsb_pkg;

    localparam int MAX_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_LEN_W = 17;
    localparam logic [CFG_LEN_W-1:0] BUFFER_LENGTH_RESET = 17'h10000;
    localparam logic REG_BUFFER_LENGTH = 1'b0;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RDA,
        ST_RDB,
        ST_MULT,
        ST_ADD,
        ST_FIN
    } state_t;

endpackage

// ===== rtl/icsb_mod.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
module icsb_mod #(
    parameter int IW = 16,
    parameter int LW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [IW-1:0] dividend,
    input  logic [LW-1:0] divisor,
    output logic          done,
    output logic [LW-1:0] remainder
);
    import icsb_pkg::*;

    localparam int CNT_W = $clog2(IW);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IW-1:0]    quo_reg;
    logic [LW-1:0]    rem_reg;
    logic [LW:0]      trial;
    logic [LW:0]      rem_next;

    always_comb begin
        trial = {rem_reg, quo_reg[IW-1]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = trial - {1'b0, divisor};
        end else begin
            rem_next = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(IW - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[IW-2:0], 1'b0};
            rem_reg <= rem_next[LW-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/interpolating_circular_sample_buffer.sv =====
// Top level of the interpolating circular sample buffer.
//
// Requests enter on the s_ channel: tuser selects a sample write or an
// interpolated read, tdata carries the sample and the 16.16 read position.
// Every request gives one result on the m_ channel: the interpolated sample
// (zero for a write) and the write pointer after the request.
// One request is handled at a time. A write stores the sample at the
// write pointer and goes to the result. For a read, the integer part is
// reduced modulo the length by a bit-serial remainder unit, one bit a
// cycle, then the sample memory is read twice, the difference is
// multiplied by the fraction and added back.
// The next request can be taken in the cycle after a result is loaded,
// so a new request is not taken while one is still being worked on.
// The APB port sets buffer_length at address 0; a write restarts the write
// pointer at zero. No clearing pass runs at reset: a fill mark makes
// entries that were never written read as zero.
// When the receiver stalls, the result holds in the output register; the
// next request is still taken and worked on, and waits for that register.
module interpolating_circular_sample_buffer #(
    parameter int MAX_DEPTH = icsb_pkg::MAX_DEPTH_DEF,
    parameter int FRAC_BITS = icsb_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // write_sample[15:0], read_position[47:16]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_sample[15:0], write_position[31:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import icsb_pkg::*;

    localparam int AW    = $clog2(MAX_DEPTH);
    localparam int LEN_W = $clog2(MAX_DEPTH + 1);
    localparam int CW    = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
    localparam int IW    = 32 - FRAC_BITS;
    localparam int PW    = FRAC_BITS + 18;

    state_t state_reg, state_next;

    logic [CFG_LEN_W-1:0] buffer_length_reg;
    logic [AW-1:0]        wp_reg;
    logic [LEN_W-1:0]     hwm_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [AW-1:0]        ia_reg;
    logic signed [15:0]   a_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [15:0]   res_sample_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;

    logic [15:0]          mem_array [MAX_DEPTH];
    logic [15:0]          mem_rdata;
    logic [AW-1:0]        rd_addr;

    logic [CW-1:0]        bl_ext;
    logic [CW-1:0]        eff_len;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     wp_inc;
    logic [AW-1:0]        wp_next;
    logic [LEN_W-1:0]     ia_inc;
    logic [AW-1:0]        ib;
    logic                 b_ok;
    logic signed [15:0]   b_val;
    logic signed [16:0]   diff;
    logic signed [PW-1:0] shifted;
    logic signed [PW-1:0] sum;
    logic [AW+15:0]       wp_ext;

    logic                 accept;
    logic                 cfg_wr;
    logic                 mem_we;
    logic                 mod_start;
    logic                 load_out;
    logic                 mod_done;
    logic [LEN_W-1:0]     mod_rem;

    assign accept = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUFFER_LENGTH) ? 32'(buffer_length_reg) : 32'd0;

    always_comb begin
        bl_ext = CW'(buffer_length_reg);
        if (bl_ext < CW'(2)) begin
            eff_len = CW'(2);
        end else if (bl_ext > CW'(MAX_DEPTH)) begin
            eff_len = CW'(MAX_DEPTH);
        end else begin
            eff_len = bl_ext;
        end
        len     = eff_len[LEN_W-1:0];
        wp_inc  = LEN_W'(wp_reg) + 1'b1;
        wp_next = (wp_inc == len) ? '0 : wp_inc[AW-1:0];
        ia_inc  = LEN_W'(ia_reg) + 1'b1;
        ib      = (ia_inc == len) ? '0 : ia_inc[AW-1:0];
        rd_addr = (state_reg == ST_RDA) ? ia_reg : ib;
        b_ok    = LEN_W'(ib) < hwm_reg;
        b_val   = b_ok ? signed'(mem_rdata) : 16'sd0;
        diff    = 17'(b_val) - 17'(a_reg);
        shifted = prod_reg >>> FRAC_BITS;
        sum     = PW'(a_reg) + shifted;
        wp_ext  = {16'd0, wp_reg};
    end

    icsb_mod #(
        .IW (IW),
        .LW (LEN_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_tdata[47:16+FRAC_BITS]),
        .divisor   (len),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mod_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0] == KIND_WRITE) begin
                        mem_we     = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        mod_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_MULT;
            ST_MULT: state_next = ST_ADD;
            ST_ADD:  state_next = ST_FIN;
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            buffer_length_reg <= BUFFER_LENGTH_RESET;
            wp_reg            <= '0;
            hwm_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == REG_BUFFER_LENGTH) begin
                buffer_length_reg <= pwdata[CFG_LEN_W-1:0];
                wp_reg            <= '0;
            end else if (mem_we) begin
                wp_reg <= wp_next;
                if (wp_inc > hwm_reg) begin
                    hwm_reg <= wp_inc;
                end
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[wp_reg] <= s_tdata[15:0];
        end
        mem_rdata <= mem_array[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            frac_reg       <= s_tdata[16+FRAC_BITS-1:16];
            res_sample_reg <= 16'sd0;
        end
        if (state_reg == ST_DIV && mod_done) begin
            ia_reg <= mod_rem[AW-1:0];
        end
        if (state_reg == ST_RDB) begin
            a_reg <= (LEN_W'(ia_reg) < hwm_reg) ? signed'(mem_rdata) : 16'sd0;
        end
        if (state_reg == ST_MULT) begin
            prod_reg <= PW'(diff) * PW'(signed'({1'b0, frac_reg}));
        end
        if (state_reg == ST_ADD) begin
            res_sample_reg <= sum[15:0];
        end
        if (load_out) begin
            m_tdata_reg <= {wp_ext[15:0], res_sample_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
